FILE: rtl/dls_pkg.sv
// shared constants, types and sigmoid table builder for the dense layer with sigmoid
// no dependencies; imported by every module of the block

package dls_pkg;

    // sizing
    localparam int MAX_NEURONS   = 64;
    localparam int VALUE_BITS    = 16;
    localparam int SIG_DEPTH     = 1024;

    localparam int FRAC_BITS     = VALUE_BITS - 4;
    localparam int ACT_BITS      = FRAC_BITS + 1;
    localparam int FIELD_BITS    = 6;
    localparam int CFG_BITS      = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int IDX_BITS      = $clog2(MAX_NEURONS);
    localparam int CNT_BITS      = $clog2(MAX_NEURONS + 1);
    localparam int W_ADDR_BITS   = $clog2(MAX_NEURONS * MAX_NEURONS);
    localparam int ACC_BITS      = 2 * VALUE_BITS + IDX_BITS + 1;
    localparam int SIG_IDX_BITS  = $clog2(SIG_DEPTH);
    localparam int SIG_SHIFT     = (VALUE_BITS > SIG_IDX_BITS) ? VALUE_BITS - SIG_IDX_BITS : 0;
    localparam int SIG_STEP      = (SIG_DEPTH < (2 ** VALUE_BITS)) ? (2 ** VALUE_BITS) / SIG_DEPTH : 1;
    localparam int WHOLE_MAX     = 2 ** (VALUE_BITS - 1 - FRAC_BITS);

    localparam int IN_TDATA_BITS  = ((2 * FIELD_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((FIELD_BITS + ACT_BITS + 7) / 8) * 8;

    // opcodes
    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_ACT    = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_COUNT  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_COUNT = CFG_IDX_BITS'(1);

    // controller to datapath
    typedef struct packed {
        logic                wr_weight;
        logic                wr_bias;
        logic                wr_act;
        logic                issue;
        logic                first;
        logic                last;
        logic                row_last;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_taken;
    } t_dp_sts;

    // exact integer sigmoid table, evaluated at elaboration
    localparam logic [63:0] FIX61 = 64'd1 << 61;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

    function automatic logic [63:0] mul61(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl, hi, mid, lo;
        ah  = a >> 32;
        al  = a & 64'hFFFF_FFFF;
        bh  = b >> 32;
        bl  = b & 64'hFFFF_FFFF;
        hi  = ah * bh;
        mid = ah * bl + al * bh;
        lo  = al * bl;
        return (hi << 3) + ((mid + (lo >> 32)) >> 29);
    endfunction

    // restoring long division by a small divisor
    function automatic logic [63:0] div_small(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-r for r in [0, 1] as a 61-bit fraction
    function automatic logic [63:0] exp_frac(input logic [63:0] r);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = $signed(FIX61);
        term = FIX61;
        for (int k = 1; k <= 26; k++) begin
            term = div_small(mul61(term, r), 64'(k));
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] n, input logic [63:0] e1);
        logic [63:0] whole, frac, res;
        whole = n >> FRAC_BITS;
        frac  = (n & (ONE_Q - 64'd1)) << (61 - FRAC_BITS);
        res   = exp_frac(frac);
        for (int j = 0; j < WHOLE_MAX; j++) begin
            if (64'(j) < whole && res != 64'd0) begin
                res = mul61(res, e1);
            end
        end
        return res;
    endfunction

    // round half up of ONE_Q / (1 + e)
    function automatic logic [63:0] sig_pos(input logic [63:0] e);
        logic [63:0] d, rem, q;
        d   = FIX61 + e;
        rem = ONE_Q;
        q   = '0;
        for (int i = 0; i < 62; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q   = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic logic [SIG_DEPTH*ACT_BITS-1:0] build_sig_rom();
        logic [SIG_DEPTH*ACT_BITS-1:0] rom;
        logic [63:0]                   e1, v;
        logic signed [63:0]            n;
        rom = '0;
        e1  = exp_frac(FIX61);
        for (int i = 0; i < SIG_DEPTH; i++) begin
            n = $signed(64'(i) * 64'(SIG_STEP)) - $signed(64'd1 << (VALUE_BITS - 1));
            if (n >= 0) begin
                v = sig_pos(exp_neg(64'(n), e1));
            end else begin
                v = ONE_Q - sig_pos(exp_neg(64'(-n), e1));
            end
            rom[i*ACT_BITS +: ACT_BITS] = v[ACT_BITS-1:0];
        end
        return rom;
    endfunction

    localparam logic [SIG_DEPTH*ACT_BITS-1:0] SIG_ROM = build_sig_rom();

endpackage

FILE: rtl/dense_layer_sigmoid.sv
// dense layer with sigmoid: loads are accepted only while idle
// a run gives output_count results from the single multiply-accumulate unit, reading
// one weight per cycle while issuing; each row waits until its result is taken
// the final activation starts a run; stages: store read, multiply, accumulate, result
// synchronous active-low reset returns to idle with both counts at 64; stores keep contents
// depends on dls_pkg, dls_ctrl and dls_datapath

module dense_layer_sigmoid (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dls_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dls_pkg::CFG_BITS-1:0]       i_cfg_data,
    // load stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // row_index [5:0], column_index [11:6], value [27:12], zero pad above
    input  logic [dls_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // opcode [1:0]
    input  logic [1:0]                         i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // neuron_index [5:0], activation [18:6], zero pad above
    output logic [dls_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,
    output logic                               o_m_tlast
);
    import dls_pkg::*;

    t_dp_cmd                cmd;
    t_dp_sts                sts;
    logic [FIELD_BITS-1:0]  in_row, in_col, out_idx;
    logic [VALUE_BITS-1:0]  in_value;
    logic [ACT_BITS-1:0]    out_act;

    // the user must change configuration only while idle; the block does not enforce it, and the port never stalls
    assign o_cfg_ready = 1'b1;

    // unpack the load transaction
    assign in_row   = i_s_tdata[FIELD_BITS-1:0];
    assign in_col   = i_s_tdata[2*FIELD_BITS-1:FIELD_BITS];
    assign in_value = i_s_tdata[2*FIELD_BITS+VALUE_BITS-1:2*FIELD_BITS];

    // sequencer: decodes loads, walks rows and columns of a run
    dls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_tvalid),
        .i_opcode    (i_s_tuser),
        .i_row       (in_row),
        .i_col       (in_col),
        .o_in_ready  (o_s_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // stores, mac pipe, sigmoid lookup and result register
    dls_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_row          (in_row),
        .i_col          (in_col),
        .i_value        (in_value),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_neuron_index (out_idx),
        .o_activation   (out_act),
        .o_last         (o_m_tlast)
    );

    // pack the result transaction
    assign o_m_tdata = OUT_TDATA_BITS'({out_act, out_idx});

`ifndef SYNTHESIS
    // no load is taken while a result is pending
    a_no_load_during_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("load ready while a result is pending");

    // delivering the final neuron ends the run
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("block not idle after final result");

    // each further neuron needs a fresh accumulation, so results never come back to back
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> (!o_m_tvalid && !o_s_tready))
        else $error("result or load ready directly after a mid-run result");
`endif

endmodule

FILE: rtl/dls_ctrl.sv
// controller: configuration registers, item decode and run sequencing
// depends on dls_pkg

module dls_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [dls_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [dls_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [1:0]                    i_opcode,
    input  logic [dls_pkg::FIELD_BITS-1:0] i_row,
    input  logic [dls_pkg::FIELD_BITS-1:0] i_col,
    output logic                          o_in_ready,
    output dls_pkg::t_dp_cmd              o_cmd,
    input  dls_pkg::t_dp_sts              i_sts
);
    import dls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_row, n_row;
    logic [IDX_BITS-1:0] r_col, n_col;
    logic [CNT_BITS-1:0] r_n_in, r_n_out;
    logic [CNT_BITS-1:0] cfg_clamped;
    logic [IDX_BITS-1:0] last_col, last_row;
    logic                in_fire, row_ok, col_ok, start;

    // 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = CNT_BITS'(1);
        end else if (CNT_BITS'(i_cfg_data) > CNT_BITS'(MAX_NEURONS)) begin
            cfg_clamped = CNT_BITS'(MAX_NEURONS);
        end else begin
            cfg_clamped = CNT_BITS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_in  <= CNT_BITS'(MAX_NEURONS);
            r_n_out <= CNT_BITS'(MAX_NEURONS);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_INPUT_COUNT) begin
                r_n_in <= cfg_clamped;
            end else if (i_cfg_index == CFG_OUTPUT_COUNT) begin
                r_n_out <= cfg_clamped;
            end
        end
    end

    assign last_col   = IDX_BITS'(r_n_in - CNT_BITS'(1));
    assign last_row   = IDX_BITS'(r_n_out - CNT_BITS'(1));
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign row_ok     = CNT_BITS'(i_row) < CNT_BITS'(MAX_NEURONS);
    assign col_ok     = CNT_BITS'(i_col) < CNT_BITS'(MAX_NEURONS);
    assign start      = o_cmd.wr_act && (CNT_BITS'(i_col) == r_n_in - CNT_BITS'(1));

    always_comb begin
        o_cmd.wr_weight = in_fire && (i_opcode == OP_WEIGHT) && row_ok && col_ok;
        o_cmd.wr_bias   = in_fire && (i_opcode == OP_BIAS) && row_ok;
        o_cmd.wr_act    = in_fire && (i_opcode == OP_ACT) && col_ok;
        o_cmd.issue     = (r_state == S_ISSUE);
        o_cmd.first     = (r_col == '0);
        o_cmd.last      = (r_col == last_col);
        o_cmd.row_last  = (r_row == last_row);
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ISSUE;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            S_ISSUE: begin
                n_col = r_col + IDX_BITS'(1);
                if (r_col == last_col) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.out_taken) begin
                    if (r_row == last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        n_row   = r_row + IDX_BITS'(1);
                        n_col   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule

FILE: rtl/dls_datapath.sv
// datapath: weight, bias and activation stores, multiply-accumulate pipe,
// saturation, sigmoid lookup and output register; depends on dls_pkg

module dls_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dls_pkg::t_dp_cmd               i_cmd,
    output dls_pkg::t_dp_sts               o_sts,
    input  logic [dls_pkg::FIELD_BITS-1:0] i_row,
    input  logic [dls_pkg::FIELD_BITS-1:0] i_col,
    input  logic [dls_pkg::VALUE_BITS-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dls_pkg::FIELD_BITS-1:0] o_neuron_index,
    output logic [dls_pkg::ACT_BITS-1:0]   o_activation,
    output logic                           o_last
);
    import dls_pkg::*;

    localparam logic signed [ACC_BITS-1:0] VAL_HI =
        (ACC_BITS'(1) <<< (VALUE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] VAL_LO = -(ACC_BITS'(1) <<< (VALUE_BITS - 1));

    logic [VALUE_BITS-1:0] weight_mem [MAX_NEURONS*MAX_NEURONS];
    logic [VALUE_BITS-1:0] bias_mem   [MAX_NEURONS];
    logic [VALUE_BITS-1:0] act_mem    [MAX_NEURONS];

    logic [W_ADDR_BITS-1:0] w_wr_addr, w_rd_addr;

    logic signed [VALUE_BITS-1:0]   r_w_rd, r_a_rd, r_b_rd;
    logic                           r_s1_vld, r_s1_first, r_s1_last;
    logic signed [2*VALUE_BITS-1:0] r_prod;
    logic                           r_s2_vld, r_s2_first, r_s2_last;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic                           r_s3_done;
    logic                           r_out_vld;
    logic [FIELD_BITS-1:0]          r_out_idx;
    logic [ACT_BITS-1:0]            r_out_act;
    logic                           r_out_last;

    logic signed [ACC_BITS-1:0]   acc_base, sum_fl;
    logic signed [VALUE_BITS-1:0] sum_sat;
    logic [VALUE_BITS-1:0]        sum_off;
    logic [SIG_IDX_BITS-1:0]      sig_idx;

    assign w_wr_addr = W_ADDR_BITS'(i_row[IDX_BITS-1:0]) * W_ADDR_BITS'(MAX_NEURONS)
                     + W_ADDR_BITS'(i_col[IDX_BITS-1:0]);
    assign w_rd_addr = W_ADDR_BITS'(i_cmd.row) * W_ADDR_BITS'(MAX_NEURONS)
                     + W_ADDR_BITS'(i_cmd.col);

    // stores: loads only while idle; reads are registered every cycle at the current row and column
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight) begin
            weight_mem[w_wr_addr] <= i_value;
        end
        r_w_rd <= weight_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bias) begin
            bias_mem[i_row[IDX_BITS-1:0]] <= i_value;
        end
        r_b_rd <= bias_mem[i_cmd.row];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_act) begin
            act_mem[i_col[IDX_BITS-1:0]] <= i_value;
        end
        r_a_rd <= act_mem[i_cmd.col];
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod     <= r_w_rd * r_a_rd;
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
    end

    // accumulate stage, seeded with the bias in product scale
    assign acc_base = r_s2_first ? (ACC_BITS'(r_b_rd) <<< FRAC_BITS) : r_acc;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= acc_base + ACC_BITS'(r_prod);
        end
    end

    // floor to value scale, saturate, table index from the offset sum
    always_comb begin
        sum_fl = r_acc >>> FRAC_BITS;
        if (sum_fl > VAL_HI) begin
            sum_sat = VAL_HI[VALUE_BITS-1:0];
        end else if (sum_fl < VAL_LO) begin
            sum_sat = VAL_LO[VALUE_BITS-1:0];
        end else begin
            sum_sat = sum_fl[VALUE_BITS-1:0];
        end
        sum_off = sum_sat ^ (VALUE_BITS'(1) << (VALUE_BITS - 1));
        sig_idx = SIG_IDX_BITS'(sum_off >> SIG_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_done) begin
            r_out_idx  <= FIELD_BITS'(i_cmd.row);
            r_out_act  <= SIG_ROM[sig_idx*ACT_BITS +: ACT_BITS];
            r_out_last <= i_cmd.row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.issue;
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld && r_s2_last;
            if (r_s3_done) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.out_taken = r_out_vld && i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_neuron_index  = r_out_idx;
    assign o_activation    = r_out_act;
    assign o_last          = r_out_last;

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for dense_layer_sigmoid: drives load and register-write transactions,
// predicts every neuron output with its own Q4.12 layer model and sigmoid table, checks the results
// depends on dls_pkg and the dense_layer_sigmoid rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dls_pkg::*;

    localparam int          LIMIT_CYCLES  = 2_000_000;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          MAX_REPORTS   = 10;
    localparam int          LUT_STEP      = (1 << VALUE_BITS) / SIG_DEPTH;
    localparam logic [63:0] UNIT61        = 64'd1 << 61;
    localparam logic [15:0] Q_MAX         = 16'h7FFF;
    localparam logic [15:0] Q_MIN         = 16'h8000;

    // one expected output neuron
    typedef struct packed {
        logic [5:0]          neuron;
        logic [ACT_BITS-1:0] level;
        logic                last;
    } t_neuron_out;

    // clock, reset and block ports; all driven inputs are known from time zero
    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
    logic [1:0]                s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;

    // layer copy kept by the testbench
    logic signed [15:0]  weight_q  [MAX_NEURONS*MAX_NEURONS];
    logic signed [15:0]  bias_q    [MAX_NEURONS];
    logic signed [15:0]  input_q   [MAX_NEURONS];
    bit                  weight_set[MAX_NEURONS*MAX_NEURONS];
    bit                  bias_set  [MAX_NEURONS];
    bit                  input_set [MAX_NEURONS];
    logic [CFG_BITS-1:0] n_in_reg  = 7'd64;
    logic [CFG_BITS-1:0] n_out_reg = 7'd64;
    logic [ACT_BITS-1:0] sigmoid_lut [SIG_DEPTH];
    t_neuron_out         expected_neurons[$];

    // flow control of both sides
    bit steady     = 1'b0;   // no idling on either side while set
    bit hold_req   = 1'b0;   // asks for one long receiver hold-off
    int hold_left  = 0;
    int stall_left = 0;

    int mismatch_count  = 0;
    int items_sent      = 0;
    int runs_started    = 0;
    int results_checked = 0;
    int cycle_count     = 0;

    dense_layer_sigmoid DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // sigmoid table, exact integer math on 61-bit fractions
    // ---------------------------------------------------------------

    // (a * b) >> 61 taken from the full 128-bit product
    function automatic logic [63:0] mul_frac61(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // e^-r for r in [0, 1], alternating taylor series with truncated terms
    function automatic logic [63:0] exp_minus_frac(logic [63:0] r);
        longint      acc;
        logic [63:0] term;
        acc  = longint'(UNIT61);
        term = UNIT61;
        for (int k = 1; k <= 26; k++) begin
            term = mul_frac61(term, r) / 64'(k);
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    // e^-(n / 2^12): fractional part by series, whole part by repeated e^-1
    function automatic logic [63:0] exp_minus(logic [63:0] n, logic [63:0] e_one);
        logic [63:0] res;
        logic [63:0] whole;
        res   = exp_minus_frac((n & ((64'd1 << FRAC_BITS) - 64'd1)) << (61 - FRAC_BITS));
        whole = n >> FRAC_BITS;
        for (logic [63:0] j = 0; j < whole && res != 64'd0; j++) begin
            res = mul_frac61(res, e_one);
        end
        return res;
    endfunction

    // 4096 / (1 + e) rounded half up, e as a 61-bit fraction
    function automatic logic [63:0] logistic_q12(logic [63:0] e);
        logic [127:0] q;
        q = (128'd1 << (FRAC_BITS + 62)) / {64'd0, UNIT61 + e};
        return 64'((q + 128'd1) >> 1);
    endfunction

    // each entry holds the sigmoid at the lower edge of its bin
    function automatic void build_sigmoid_lut();
        logic [63:0] e_one;
        longint      x;
        e_one = exp_minus_frac(UNIT61);
        for (int i = 0; i < SIG_DEPTH; i++) begin
            x = longint'(i) * LUT_STEP - 32768;
            if (x >= 0) begin
                sigmoid_lut[i] = ACT_BITS'(logistic_q12(exp_minus(64'(x), e_one)));
            end else begin
                // negative side mirrors the positive one: 1 - sigmoid(-x)
                sigmoid_lut[i] = ACT_BITS'((64'd1 << FRAC_BITS)
                                           - logistic_q12(exp_minus(64'(-x), e_one)));
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // layer prediction
    // ---------------------------------------------------------------

    // count registers: zero acts as one, anything above the array size as the array size
    function automatic int eff_count(logic [CFG_BITS-1:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > MAX_NEURONS) ? MAX_NEURONS : int'(v);
    endfunction

    // one layer pass: every output neuron in order, last one flagged
    function automatic void predict_layer();
        int          n_in;
        int          n_out;
        int          slot;
        longint      acc;
        longint      sum;
        t_neuron_out o;
        n_in  = eff_count(n_in_reg);
        n_out = eff_count(n_out_reg);
        for (int r = 0; r < n_out; r++) begin
            // bias lines up with the Q8.24 products; the longint sum cannot overflow here
            acc = longint'(bias_q[r]) * (longint'(1) << FRAC_BITS);
            for (int c = 0; c < n_in; c++) begin
                acc += longint'(weight_q[r*MAX_NEURONS + c]) * longint'(input_q[c]);
            end
            // floor to Q4.12, then saturate to [-8, 8)
            sum = acc >>> FRAC_BITS;
            if (sum > 32767) begin
                sum = 32767;
            end
            if (sum < -32768) begin
                sum = -32768;
            end
            slot     = int'((sum + 32768) / LUT_STEP);
            o.neuron = 6'(r);
            o.level  = sigmoid_lut[slot];
            o.last   = (r == n_out - 1);
            expected_neurons.push_back(o);
        end
        runs_started++;
    endfunction

    // state update for one accepted load transaction
    function automatic void apply_load(t_opcode op, logic [5:0] row, logic [5:0] col,
                                       logic [15:0] val);
        case (op)
            OP_WEIGHT: begin
                weight_q[{row, col}]   = val;
                weight_set[{row, col}] = 1'b1;
            end
            OP_BIAS: begin
                bias_q[row]   = val;
                bias_set[row] = 1'b1;
            end
            OP_ACT: begin
                input_q[col]   = val;
                input_set[col] = 1'b1;
                // only the final input column launches a pass
                if (int'(col) == eff_count(n_in_reg) - 1) begin
                    predict_layer();
                end
            end
            default: ;  // reserved opcode is dropped
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly small magnitudes so sums land inside the table, plus extremes
    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5, 6: return 16'($urandom_range(0, 2047)) - 16'd1024;
            7:       return 16'($urandom_range(0, 16383)) - 16'd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    // one load transaction; called and returns at a falling edge, valid stays high
    task automatic send_load(t_opcode op, logic [5:0] row, logic [5:0] col, logic [15:0] val);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_BITS'({val, col, row});
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        apply_load(op, row, col, val);
        items_sent++;
        @(negedge i_clk);
    endtask

    // loads every store entry the coming pass reads that was never written
    task automatic fill_missing();
        int n_in;
        int n_out;
        n_in  = eff_count(n_in_reg);
        n_out = eff_count(n_out_reg);
        for (int r = 0; r < n_out; r++) begin
            if (!bias_set[r]) begin
                send_load(OP_BIAS, 6'(r), 6'd0, rand_value());
            end
            for (int c = 0; c < n_in; c++) begin
                if (!weight_set[r*MAX_NEURONS + c]) begin
                    send_load(OP_WEIGHT, 6'(r), 6'(c), rand_value());
                end
            end
        end
        for (int c = 0; c < n_in - 1; c++) begin
            if (!input_set[c]) begin
                send_load(OP_ACT, 6'd0, 6'(c), rand_value());
            end
        end
    endtask

    // load with a guard so that a pass never reads an unwritten entry
    task automatic load_item(t_opcode op, logic [5:0] row, logic [5:0] col, logic [15:0] val);
        if (op == OP_ACT && int'(col) == eff_count(n_in_reg) - 1) begin
            fill_missing();
        end
        send_load(op, row, col, val);
    endtask

    // sender drops valid and waits for the block to drain and go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_neurons.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // writes both count registers while the block is idle
    task automatic set_layer(logic [CFG_BITS-1:0] n_in, logic [CFG_BITS-1:0] n_out);
        settle();
        for (int k = 0; k < 2; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? CFG_INPUT_COUNT : CFG_OUTPUT_COUNT;
            cfg_data  <= (k == 0) ? n_in : n_out;
            @(posedge i_clk);
            while (!cfg_ready) begin
                @(posedge i_clk);
            end
            if (k == 0) begin
                n_in_reg = n_in;
            end else begin
                n_out_reg = n_out;
            end
            @(negedge i_clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // random mix: mostly well-formed layer loading, a quarter pass launches, some noise
    task automatic random_items(int count);
        int          pick;
        int          n_in;
        int          n_out;
        t_opcode     op;
        logic [5:0]  row;
        logic [5:0]  col;
        for (int i = 0; i < count; i++) begin
            n_in  = eff_count(n_in_reg);
            n_out = eff_count(n_out_reg);
            pick  = $urandom_range(0, 99);
            row   = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, n_out - 1));
            col   = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, n_in - 1));
            if (pick < 40) begin
                op = OP_WEIGHT;
            end else if (pick < 55) begin
                op = OP_BIAS;
            end else if (pick < 70) begin
                op = OP_ACT;
            end else if (pick < 95) begin
                op  = OP_ACT;
                col = 6'(n_in - 1);
            end else begin
                op = OP_RSVD;
            end
            load_item(op, row, col, rand_value());
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // 2x2 layer: saturation both ways, zero sum, flooring of a tiny negative sum,
    // an activation at a non-final column and a reserved opcode
    task automatic test_directed_cases();
        set_layer(7'd2, 7'd2);
        load_item(OP_WEIGHT, 6'd0, 6'd0, Q_MAX);
        load_item(OP_WEIGHT, 6'd0, 6'd1, Q_MAX);
        load_item(OP_WEIGHT, 6'd1, 6'd0, Q_MIN);
        load_item(OP_WEIGHT, 6'd1, 6'd1, Q_MIN);
        load_item(OP_BIAS,   6'd0, 6'd0, Q_MAX);
        load_item(OP_BIAS,   6'd1, 6'd0, Q_MIN);
        load_item(OP_ACT,    6'd0, 6'd0, Q_MAX);   // stored, no pass
        load_item(OP_RSVD,   6'd1, 6'd1, Q_MAX);   // dropped even at the final column
        load_item(OP_ACT,    6'd0, 6'd1, Q_MAX);   // high and low saturation
        load_item(OP_BIAS,   6'd0, 6'd0, 16'h0000);
        load_item(OP_BIAS,   6'd1, 6'd0, 16'h0000);
        load_item(OP_ACT,    6'd0, 6'd0, 16'h0000);
        load_item(OP_ACT,    6'd0, 6'd1, 16'h0000); // zero sum, middle of the table
        load_item(OP_WEIGHT, 6'd0, 6'd0, 16'hFFFF);
        load_item(OP_ACT,    6'd0, 6'd0, 16'h0001);
        load_item(OP_ACT,    6'd0, 6'd1, 16'h0000); // sum of -1 lsb floors below zero
    endtask

    // smallest layer
    task automatic test_single_neuron();
        set_layer(7'd1, 7'd1);
        random_items(20);
    endtask

    // one input feeding all 64 outputs, loaded without idling; the receiver then holds
    // off for a long stretch while loads keep coming, so the block fills and stalls its input
    task automatic test_wide_output_backpressure();
        set_layer(7'd1, 7'd64);
        steady = 1'b1;
        fill_missing();
        steady   = 1'b0;
        hold_req = 1'b1;
        load_item(OP_ACT, 6'd0, 6'd0, rand_value());
        random_items(12);
        settle();
        load_item(OP_ACT, 6'd0, 6'd0, rand_value());
    endtask

    // counts outside 1..64: zero acts as one, 127 as 64
    task automatic test_count_limits();
        set_layer(7'd0, 7'd127);
        random_items(10);
        load_item(OP_ACT, 6'd0, 6'd0, rand_value());
        set_layer(7'd127, 7'd0);
        random_items(10);
        load_item(OP_ACT, 6'd0, 6'd63, rand_value());
    endtask

    // both extreme shapes, then small layer shapes, with idle-free phases in between
    task automatic test_random_layers();
        logic [CFG_BITS-1:0] n_in;
        logic [CFG_BITS-1:0] n_out;
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                n_in  = 7'd1;
                n_out = 7'd64;
            end else if (p == 1) begin
                n_in  = 7'd64;
                n_out = 7'd1;
            end else begin
                n_in  = 7'($urandom_range(1, 8));
                n_out = 7'($urandom_range(1, 8));
            end
            set_layer(n_in, n_out);
            steady = (p == 3 || p == 6);
            random_items(12);
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver side and checking
    // ---------------------------------------------------------------

    // long receiver hold-off, counted here on its own
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end
    end

    // ready drops for the drawn stall after each result transaction
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_neuron_out want;
        if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
            stall_left <= steady ? 0 : $urandom_range(0, 4);
            results_checked++;
            if (expected_neurons.size() == 0) begin
                note_mismatch("unexpected result, neuron_index", 32'hFFFF_FFFF,
                              32'(m_tdata[5:0]));
            end else begin
                want = expected_neurons.pop_front();
                if (m_tdata[5:0] !== want.neuron) begin
                    note_mismatch("neuron_index", 32'(want.neuron), 32'(m_tdata[5:0]));
                end
                if (m_tdata[6 +: ACT_BITS] !== want.level) begin
                    note_mismatch("activation", 32'(want.level), 32'(m_tdata[6 +: ACT_BITS]));
                end
                if (m_tlast !== want.last) begin
                    note_mismatch("last", 32'(want.last), 32'(m_tlast));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_neurons.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        build_sigmoid_lut();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_single_neuron();
        test_wide_output_backpressure();
        test_count_limits();
        test_random_layers();

        // drain, then give the block time to show any stray result
        s_tvalid <= 1'b0;
        while (expected_neurons.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d load transactions, %0d layer passes, %0d neuron results checked",
                 items_sent, runs_started, results_checked);
        $display("layers 1x1 up to 64 inputs or 64 outputs, count limits, saturation both ways,"
                 , " long output stall");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
